/* sv/trl_pkg.sv */
// trl_pkg: widths, beat types and register indexes for the three-beacon trilateration block
// depends on nothing; imported by every trl module and the top level
package trl_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int CFG_IDX_W   = 3;

    localparam int DIFF_W = COORD_WIDTH + 2;          // pairwise coefficient a, b, d, e
    localparam int SQ_W   = 2 * COORD_WIDTH;          // squares
    localparam int CW     = 2 * COORD_WIDTH + 3;      // right-hand side c, f
    localparam int PW     = CW + DIFF_W;              // c*e style products
    localparam int EW     = 2 * DIFF_W;               // e*a style products
    localparam int DW     = EW + 1;                   // determinant
    localparam int NW     = PW + 1;                   // numerators
    localparam int RW     = NW + 1;                   // rounded dividend / remainder
    localparam int DVW    = DW + 1;                   // doubled divisor
    localparam int QW     = COORD_WIDTH + 1;          // quotient incl. overflow bit
    localparam int FRONT_STAGES = 5;
    localparam int DIV_CELLS    = QW;

    localparam logic [CFG_IDX_W-1:0] REG_DEPART_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEPART_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_X = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ARRIVE_Y = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_THIRD_X  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_THIRD_Y  = 3'd5;

    typedef struct packed {
        logic [COORD_WIDTH-1:0] distance_depart;
        logic [COORD_WIDTH-1:0] distance_arrive;
        logic [COORD_WIDTH-1:0] distance_third;
    } trl_in_t;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] position_x;
        logic signed [COORD_WIDTH-1:0] position_y;
        logic                          degenerate;
        logic                          overflow;
    } trl_out_t;

    typedef struct packed {
        logic [RW-1:0]  rem_x;
        logic [RW-1:0]  rem_y;
        logic [DVW-1:0] dvs;
        logic [QW-1:0]  quo_x;
        logic [QW-1:0]  quo_y;
        logic           neg_x;
        logic           neg_y;
        logic           degen;
    } trl_div_t;

endpackage

/* sv/trilateration_three_beacon.sv */
// trilateration_three_beacon: top level, beacon registers, stage valids and the cell chain
// depends on trl_pkg, trl_front, trl_div_cell, trl_sat
//
// Takes one distance triple per clock while the output is not stalled and returns one
// position beat per triple, in order, through 5 arithmetic stages, 17 division cells of
// one quotient bit each and 1 output register. Each stage holds its beat until the stage
// after it is free, so a stall at the output fills the pipeline before in_ready drops.
// Positions are signed Q8.8, rounded to nearest with ties away from zero; degenerate is
// set with a zero position when the beacons are collinear or coincide, and overflow when a
// coordinate saturated. The user must write beacon registers only while idle; not enforced.
module trilateration_three_beacon (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  trl_pkg::trl_in_t                     in_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output trl_pkg::trl_out_t                    out_data,
    input  logic                                 cfg_we,
    input  logic [trl_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [trl_pkg::COORD_WIDTH-1:0]      cfg_data
);
    import trl_pkg::*;

    localparam int STAGES = FRONT_STAGES + DIV_CELLS + 1;

    logic signed [COORD_WIDTH-1:0] x1_reg, y1_reg, x2_reg, y2_reg, x3_reg, y3_reg;
    logic [STAGES-1:0]             vld_reg;
    logic [STAGES-1:0]             vld_next;
    logic [STAGES-1:0]             free;
    trl_div_t                      chain [DIV_CELLS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x1_reg <= '0;
            y1_reg <= '0;
            x2_reg <= '0;
            y2_reg <= '0;
            x3_reg <= '0;
            y3_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEPART_X: x1_reg <= cfg_data;
                REG_DEPART_Y: y1_reg <= cfg_data;
                REG_ARRIVE_X: x2_reg <= cfg_data;
                REG_ARRIVE_Y: y2_reg <= cfg_data;
                REG_THIRD_X:  x3_reg <= cfg_data;
                REG_THIRD_Y:  y3_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // a stage loads when it is empty or its beat moves on
    always_comb
    begin
        free[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            free[k] = !vld_reg[k] || free[k+1];
        end
        vld_next[0] = free[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            if (free[k])
            begin
                vld_next[k] = vld_reg[k-1];
            end
            else
            begin
                vld_next[k] = vld_reg[k];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign in_ready  = free[0];
    assign out_valid = vld_reg[STAGES-1];

    trl_front u_front (
        .clk      (clk),
        .en       (free[FRONT_STAGES-1:0]),
        .in_data  (in_data),
        .x1       (x1_reg),
        .y1       (y1_reg),
        .x2       (x2_reg),
        .y2       (y2_reg),
        .x3       (x3_reg),
        .y3       (y3_reg),
        .div_data (chain[0])
    );

    for (genvar k = 0; k < DIV_CELLS; k++)
    begin : g_cell
        trl_div_cell #(
            .SHIFT (DIV_CELLS - 1 - k)
        ) u_cell (
            .clk  (clk),
            .en   (free[FRONT_STAGES + k]),
            .prev (chain[k]),
            .next (chain[k+1])
        );
    end

    trl_sat u_sat (
        .clk      (clk),
        .en       (free[STAGES-1]),
        .prev     (chain[DIV_CELLS]),
        .out_data (out_data)
    );

endmodule

/* sv/trl_front.sv */
// trl_front: five-stage pipeline from distances and beacon positions to divider operands
// depends on trl_pkg
module trl_front (
    input  logic                                   clk,
    input  logic [trl_pkg::FRONT_STAGES-1:0]        en,
    input  trl_pkg::trl_in_t                        in_data,
    input  logic signed [trl_pkg::COORD_WIDTH-1:0]  x1,
    input  logic signed [trl_pkg::COORD_WIDTH-1:0]  y1,
    input  logic signed [trl_pkg::COORD_WIDTH-1:0]  x2,
    input  logic signed [trl_pkg::COORD_WIDTH-1:0]  y2,
    input  logic signed [trl_pkg::COORD_WIDTH-1:0]  x3,
    input  logic signed [trl_pkg::COORD_WIDTH-1:0]  y3,
    output trl_pkg::trl_div_t                       div_data
);
    import trl_pkg::*;

    // stage 0: squares and coefficients
    logic [SQ_W-1:0]          dsq1_reg, dsq2_reg, dsq3_reg;
    logic signed [SQ_W-1:0]   xs1_reg, ys1_reg, xs2_reg, ys2_reg, xs3_reg, ys3_reg;
    logic signed [DIFF_W-1:0] a0_reg, b0_reg, d0_reg, e0_reg;
    // stage 1
    logic signed [CW-1:0]     c1_reg, f1_reg;
    logic signed [DIFF_W-1:0] a1_reg, b1_reg, d1_reg, e1_reg;
    // stage 2
    logic signed [PW-1:0]     ce_reg, fb_reg, af_reg, cd_reg;
    logic signed [EW-1:0]     ea_reg, bd_reg;
    // stage 3
    logic signed [NW-1:0]     nx_reg, ny_reg;
    logic signed [DW-1:0]     det_reg;
    // stage 4
    trl_div_t                 out_reg;

    logic signed [CW-1:0]     c1_next, f1_next;
    logic signed [PW-1:0]     ce_next, fb_next, af_next, cd_next;
    logic signed [EW-1:0]     ea_next, bd_next;
    logic [NW-1:0]            ax, ay;
    logic [DW-1:0]            adet;
    trl_div_t                 out_next;

    function automatic logic signed [DIFF_W-1:0] twice_diff(
        input logic signed [COORD_WIDTH-1:0] p,
        input logic signed [COORD_WIDTH-1:0] q
    );
        logic signed [DIFF_W-2:0] t;
        t = (DIFF_W-1)'(q) - (DIFF_W-1)'(p);
        return {t, 1'b0};
    endfunction

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            dsq1_reg <= in_data.distance_depart * in_data.distance_depart;
            dsq2_reg <= in_data.distance_arrive * in_data.distance_arrive;
            dsq3_reg <= in_data.distance_third * in_data.distance_third;
            xs1_reg  <= x1 * x1;
            ys1_reg  <= y1 * y1;
            xs2_reg  <= x2 * x2;
            ys2_reg  <= y2 * y2;
            xs3_reg  <= x3 * x3;
            ys3_reg  <= y3 * y3;
            a0_reg   <= twice_diff(x1, x2);
            b0_reg   <= twice_diff(y1, y2);
            d0_reg   <= twice_diff(x2, x3);
            e0_reg   <= twice_diff(y2, y3);
        end
    end

    always_comb
    begin
        c1_next = CW'($signed({1'b0, dsq1_reg})) - CW'($signed({1'b0, dsq2_reg}))
                + CW'(xs2_reg) + CW'(ys2_reg) - CW'(xs1_reg) - CW'(ys1_reg);
        f1_next = CW'($signed({1'b0, dsq2_reg})) - CW'($signed({1'b0, dsq3_reg}))
                + CW'(xs3_reg) + CW'(ys3_reg) - CW'(xs2_reg) - CW'(ys2_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            c1_reg <= c1_next;
            f1_reg <= f1_next;
            a1_reg <= a0_reg;
            b1_reg <= b0_reg;
            d1_reg <= d0_reg;
            e1_reg <= e0_reg;
        end
    end

    always_comb
    begin
        ce_next = PW'(c1_reg) * PW'(e1_reg);
        fb_next = PW'(f1_reg) * PW'(b1_reg);
        af_next = PW'(a1_reg) * PW'(f1_reg);
        cd_next = PW'(c1_reg) * PW'(d1_reg);
        ea_next = EW'(e1_reg) * EW'(a1_reg);
        bd_next = EW'(b1_reg) * EW'(d1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            ce_reg <= ce_next;
            fb_reg <= fb_next;
            af_reg <= af_next;
            cd_reg <= cd_next;
            ea_reg <= ea_next;
            bd_reg <= bd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            nx_reg  <= NW'(ce_reg) - NW'(fb_reg);
            ny_reg  <= NW'(af_reg) - NW'(cd_reg);
            det_reg <= DW'(ea_reg) - DW'(bd_reg);
        end
    end

    // rounded quotient: (2|n| + |det|) / (2|det|)
    always_comb
    begin
        ax   = nx_reg[NW-1] ? NW'(-nx_reg) : NW'(nx_reg);
        ay   = ny_reg[NW-1] ? NW'(-ny_reg) : NW'(ny_reg);
        adet = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        out_next.rem_x = {ax, 1'b0} + RW'(adet);
        out_next.rem_y = {ay, 1'b0} + RW'(adet);
        out_next.dvs   = {adet, 1'b0};
        out_next.quo_x = '0;
        out_next.quo_y = '0;
        out_next.neg_x = nx_reg[NW-1] ^ det_reg[DW-1];
        out_next.neg_y = ny_reg[NW-1] ^ det_reg[DW-1];
        out_next.degen = (det_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            out_reg <= out_next;
        end
    end

    assign div_data = out_reg;

endmodule

/* sv/trl_div_cell.sv */
// trl_div_cell: one restoring-division cell, settles one quotient bit of x and of y
// depends on trl_pkg
module trl_div_cell #(
    parameter int SHIFT = 0
) (
    input  logic              clk,
    input  logic              en,
    input  trl_pkg::trl_div_t prev,
    output trl_pkg::trl_div_t next
);
    import trl_pkg::*;

    trl_div_t      cell_reg;
    trl_div_t      cell_next;
    logic [RW-1:0] dsh;
    logic          bit_x, bit_y;

    always_comb
    begin
        dsh       = RW'(prev.dvs) << SHIFT;
        bit_x     = prev.rem_x >= dsh;
        bit_y     = prev.rem_y >= dsh;
        cell_next = prev;
        cell_next.rem_x = bit_x ? prev.rem_x - dsh : prev.rem_x;
        cell_next.rem_y = bit_y ? prev.rem_y - dsh : prev.rem_y;
        cell_next.quo_x = {prev.quo_x[QW-2:0], bit_x};
        cell_next.quo_y = {prev.quo_y[QW-2:0], bit_y};
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cell_reg <= cell_next;
        end
    end

    assign next = cell_reg;

endmodule

/* sv/trl_sat.sv */
// trl_sat: output register, applies sign, saturation and the degenerate case
// depends on trl_pkg
module trl_sat (
    input  logic              clk,
    input  logic              en,
    input  trl_pkg::trl_div_t prev,
    output trl_pkg::trl_out_t out_data
);
    import trl_pkg::*;

    trl_out_t out_reg;
    trl_out_t out_next;

    function automatic logic [COORD_WIDTH:0] fix(
        input logic [QW-1:0] quo,
        input logic          neg
    );
        logic [QW-1:0]          lim;
        logic                   sat;
        logic [QW-1:0]          mag;
        logic [COORD_WIDTH-1:0] val;
        lim = neg ? (QW'(1) << (COORD_WIDTH - 1)) : (QW'(1) << (COORD_WIDTH - 1)) - QW'(1);
        sat = quo[QW-1] || (quo > lim);
        mag = sat ? lim : quo;
        val = neg ? COORD_WIDTH'(-mag) : mag[COORD_WIDTH-1:0];
        return {sat, val};
    endfunction

    logic [COORD_WIDTH:0] rx, ry;

    always_comb
    begin
        rx = fix(prev.quo_x, prev.neg_x);
        ry = fix(prev.quo_y, prev.neg_y);
        if (prev.degen)
        begin
            out_next.position_x = '0;
            out_next.position_y = '0;
            out_next.degenerate = 1'b1;
            out_next.overflow   = 1'b0;
        end
        else
        begin
            out_next.position_x = rx[COORD_WIDTH-1:0];
            out_next.position_y = ry[COORD_WIDTH-1:0];
            out_next.degenerate = 1'b0;
            out_next.overflow   = rx[COORD_WIDTH] | ry[COORD_WIDTH];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_reg <= out_next;
        end
    end

    assign out_data = out_reg;

endmodule

/* test/tb_trilateration_three_beacon.sv */
// tb_trilateration_three_beacon: self-checking bench for the three-beacon trilateration block
// drives distance triples and beacon settings, predicts each position beat and compares
// depends on trl_pkg and trilateration_three_beacon
`timescale 1ns / 100ps

module tb_trilateration_three_beacon;
    import trl_pkg::*;

    localparam int LATENCY = 23;
    localparam int N_RANDOM = 930;

    typedef struct {
        trl_in_t  dists;
        bit       known;
        trl_out_t want;
    } stim_row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    trl_in_t in_data;
    logic out_valid;
    logic out_ready;
    trl_out_t out_data;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COORD_WIDTH-1:0] cfg_data;

    logic signed [COORD_WIDTH-1:0] beacon [6];
    trl_out_t pending_pos [$];
    int mismatches;
    int beats_in;
    int beats_out;
    int degen_seen;
    int sat_seen;
    int send_idle_pct;
    int recv_stall_pct;

    trilateration_three_beacon dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // rounded quotient, ties away from zero, saturated to coordinate range
    function automatic logic signed [COORD_WIDTH-1:0] round_sat(
        input logic signed [127:0] num, input logic signed [127:0] den, inout bit sat);
        logic [127:0] an;
        logic [127:0] ad;
        logic [127:0] q;
        logic [127:0] lim;
        bit neg;
        neg = (num < 0) != (den < 0);
        an = (num < 0) ? -num : num;
        ad = (den < 0) ? -den : den;
        q = (2 * an + ad) / (2 * ad);
        lim = (128'd1 << (COORD_WIDTH - 1)) - (neg ? 0 : 1);
        if (q > lim)
        begin
            q = lim;
            sat = 1'b1;
        end
        return neg ? -q[COORD_WIDTH-1:0] : q[COORD_WIDTH-1:0];
    endfunction

    function automatic trl_out_t solve_position(input trl_in_t dists);
        logic signed [127:0] x1, y1, x2, y2, x3, y3;
        logic signed [127:0] d1, d2, d3;
        logic signed [127:0] a, b, c, d, e, f, det;
        trl_out_t r;
        bit sat;
        x1 = beacon[REG_DEPART_X];
        y1 = beacon[REG_DEPART_Y];
        x2 = beacon[REG_ARRIVE_X];
        y2 = beacon[REG_ARRIVE_Y];
        x3 = beacon[REG_THIRD_X];
        y3 = beacon[REG_THIRD_Y];
        d1 = {112'd0, dists.distance_depart};
        d2 = {112'd0, dists.distance_arrive};
        d3 = {112'd0, dists.distance_third};
        a = 2 * (x2 - x1);
        b = 2 * (y2 - y1);
        d = 2 * (x3 - x2);
        e = 2 * (y3 - y2);
        c = d1 * d1 - d2 * d2 + (x2 * x2 + y2 * y2) - (x1 * x1 + y1 * y1);
        f = d2 * d2 - d3 * d3 + (x3 * x3 + y3 * y3) - (x2 * x2 + y2 * y2);
        det = e * a - b * d;
        r = '0;
        sat = 1'b0;
        if (det == 0)
        begin
            r.degenerate = 1'b1;
            return r;
        end
        r.position_x = round_sat(c * e - f * b, det, sat);
        r.position_y = round_sat(a * f - c * d, det, sat);
        r.overflow = sat;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        $display("mismatch beat %0d: %s got %0d want %0d", beats_out, what, got, want);
    endtask

    task automatic write_beacon(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (idx < 6)
            beacon[idx] = val;
        @(posedge clk);
    endtask

    task automatic drain_pipeline();
        while (pending_pos.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic place_beacons(input logic [15:0] v0, v1, v2, v3, v4, v5);
        drain_pipeline();
        write_beacon(REG_DEPART_X, v0);
        write_beacon(REG_DEPART_Y, v1);
        write_beacon(REG_ARRIVE_X, v2);
        write_beacon(REG_ARRIVE_Y, v3);
        write_beacon(REG_THIRD_X, v4);
        write_beacon(REG_THIRD_Y, v5);
    endtask

    // beats stay on the bus until taken; a next beat is loaded in the same step
    task automatic send_triple(input trl_in_t dists, input bit known, input trl_out_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= dists;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_pos.push_back(known ? want : solve_position(dists));
        beats_in++;
    endtask

    function automatic trl_in_t rand_triple(input int span);
        trl_in_t t;
        t.distance_depart = 16'($urandom_range(span));
        t.distance_arrive = 16'($urandom_range(span));
        t.distance_third = 16'($urandom_range(span));
        return t;
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pos.size() == 0)
                report_mismatch("unexpected beat", 1, 0);
            else
            begin
                trl_out_t w;
                w = pending_pos.pop_front();
                if (out_data.position_x !== w.position_x)
                    report_mismatch("position_x", out_data.position_x, w.position_x);
                if (out_data.position_y !== w.position_y)
                    report_mismatch("position_y", out_data.position_y, w.position_y);
                if (out_data.degenerate !== w.degenerate)
                    report_mismatch("degenerate", out_data.degenerate, w.degenerate);
                if (out_data.overflow !== w.overflow)
                    report_mismatch("overflow", out_data.overflow, w.overflow);
                degen_seen += w.degenerate;
                sat_seen += w.overflow;
            end
            beats_out++;
        end
    end

    always @(posedge clk)
        out_ready <= ($urandom_range(99) >= recv_stall_pct);

    initial
    begin
        #50_000_000;
        $display("trilateration_three_beacon verification failed");
        $finish;
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        int phase;
        int span;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        beats_in = 0;
        beats_out = 0;
        degen_seen = 0;
        sat_seen = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < 6; i++)
            beacon[i] = '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // all beacons at origin after reset: degenerate
        row.known = 1'b1;
        row.want = '{position_x: 0, position_y: 0, degenerate: 1'b1, overflow: 1'b0};
        row.dists = '{16'h0000, 16'h0000, 16'h0000};
        rows.push_back(row);
        row.dists = '{16'hffff, 16'hffff, 16'hffff};
        rows.push_back(row);
        foreach (rows[i])
            send_triple(rows[i].dists, rows[i].known, rows[i].want);
        rows.delete();

        // right triangle of unit scale, and an out-of-range index write
        in_valid <= 1'b0;
        place_beacons(16'h0000, 16'h0000, 16'h0100, 16'h0000, 16'h0000, 16'h0100);
        write_beacon(3'd7, 16'h1234);
        row.known = 1'b0;
        for (int i = 0; i < 6; i++)
        begin
            row.dists = '{16'(i * 16'h2a5b), 16'(16'hffff - i * 16'h3001), 16'(i * 16'h1111)};
            rows.push_back(row);
        end
        row.dists = '{16'h0000, 16'hffff, 16'h0000};
        rows.push_back(row);
        row.dists = '{16'hffff, 16'h0000, 16'hffff};
        rows.push_back(row);
        row.dists = '{16'h0000, 16'h0000, 16'hffff};
        rows.push_back(row);
        foreach (rows[i])
            send_triple(rows[i].dists, rows[i].known, rows[i].want);
        rows.delete();

        // extremes of coordinates, then collinear beacons
        in_valid <= 1'b0;
        place_beacons(16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        for (int i = 0; i < 4; i++)
            send_triple(rand_triple(65535), 1'b0, '0);
        in_valid <= 1'b0;
        place_beacons(16'h0000, 16'h0000, 16'h0100, 16'h0100, 16'h0200, 16'h0200);
        row.known = 1'b1;
        row.want = '{position_x: 0, position_y: 0, degenerate: 1'b1, overflow: 1'b0};
        row.dists = '{16'h1234, 16'hfedc, 16'h0001};
        send_triple(row.dists, row.known, row.want);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            phase = n / (N_RANDOM / 5);
            if (n % 93 == 0)
            begin
                in_valid <= 1'b0;
                case ($urandom_range(3))
                    0: place_beacons(16'($urandom), 16'($urandom), 16'($urandom),
                                     16'($urandom), 16'($urandom), 16'($urandom));
                    1: place_beacons(16'($urandom_range(4095)), 16'($urandom_range(4095)),
                                     16'($urandom_range(4095)), 16'($urandom_range(4095)),
                                     16'($urandom_range(4095)), 16'($urandom_range(4095)));
                    2: place_beacons(16'h0000, 16'h0000, 16'h0a00, 16'h0000,
                                     16'h0000, 16'h0a00);
                    default: place_beacons(16'h0300, 16'h0300, 16'h0300, 16'h0300,
                                           16'($urandom), 16'($urandom));
                endcase
            end
            case (phase)
                0: begin send_idle_pct = 0; recv_stall_pct = 0; end
                1: begin send_idle_pct = 88; recv_stall_pct = 0; end
                2: begin send_idle_pct = 0; recv_stall_pct = 88; end
                3: begin send_idle_pct = 24; recv_stall_pct = 24; end
                default: begin send_idle_pct = 0; recv_stall_pct = 0; end
            endcase
            if (n == N_RANDOM / 2)
            begin
                in_valid <= 1'b0;
                drain_pipeline();
            end
            span = ($urandom_range(3) == 0) ? 65535 : 4095;
            send_triple(rand_triple(span), 1'b0, '0);
        end
        in_valid <= 1'b0;
        recv_stall_pct = 0;
        drain_pipeline();

        $display("sent %0d triples, received %0d positions", beats_in, beats_out);
        $display("degenerate cases %0d, saturated cases %0d", degen_seen, sat_seen);
        if (mismatches == 0 && pending_pos.size() == 0)
            $display("trilateration_three_beacon verification clean");
        else
            $display("trilateration_three_beacon verification failed");
        $finish;
    end

endmodule

/* sim.f */
sv/trl_pkg.sv
sv/trl_front.sv
sv/trl_div_cell.sv
sv/trl_sat.sv
sv/trilateration_three_beacon.sv
test/tb_trilateration_three_beacon.sv
